/* hdl/led_blink_sequencer_assert.svh */
// Assertion macros for the LED blink sequencer.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LED_BLINK_SEQUENCER_ASSERT_SVH
`define LED_BLINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define LBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off during reset.
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lbs_pkg.sv */
// Shared types and constants of the LED blink sequencer.
// Used by lbs_step and led_blink_sequencer; no dependencies.
package lbs_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int PAT_W          = 16;
    localparam int NOW_W          = 32;
    localparam int MODE_W         = 5;
    localparam int CFG_IDX_W      = 3;

    typedef logic [PAT_W-1:0]  t_pat;
    typedef logic [MODE_W-1:0] t_mode;

    // Mode flag masks
    localparam t_mode MODE_ON    = 5'b00001;
    localparam t_mode MODE_BLINK = 5'b00010;
    localparam t_mode MODE_FLASH = 5'b00100;
    localparam t_mode MODE_STOP  = 5'b01000;
    localparam t_mode MODE_ONCE  = 5'b10000;
    localparam t_mode MODE_NONE  = 5'b00000;

    localparam t_pat PRESET_PERIOD = 16'd200;
    localparam t_pat PRESET_COUNT  = 16'd2;

    // Reset values of the configuration registers
    localparam t_pat ALL_OFF_RST = 16'hFFFF;
    localparam t_pat BLUE_ON_RST = 16'h0000;
    localparam t_pat RED_RST     = 16'hBFFF;
    localparam t_pat GREEN_RST   = 16'h7FFF;

    typedef enum logic [3:0] {
        OP_TICK      = 4'd0,
        OP_BLINK     = 4'd1,
        OP_ON        = 4'd2,
        OP_OFF       = 4'd3,
        OP_PRESET    = 4'd4,
        OP_FLASH     = 4'd5,
        OP_STOP      = 4'd6,
        OP_ON_ONCE   = 4'd7,
        OP_BATT_ON   = 4'd8,
        OP_BATT_OFF  = 4'd9,
        OP_OPEN_ON   = 4'd10,
        OP_OPEN_OFF  = 4'd11
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALL_OFF  = 3'd0,
        CFG_BLUE_ON  = 3'd1,
        CFG_RED      = 3'd2,
        CFG_GREEN    = 3'd3,
        CFG_BATT     = 3'd4,
        CFG_OPEN     = 3'd5,
        CFG_SLEEP    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_pat all_off;
        t_pat blue_on;
        t_pat red;
        t_pat green;
        t_pat batt_mask;
        t_pat open_mask;
        logic sleep;
    } t_cfg;

    // First member sits in the top bits: opcode lands in the lowest bits.
    typedef struct packed {
        t_pat             off_time;
        t_pat             on_time;
        t_pat             blink_count;
        t_pat             display_code;
        logic [NOW_W-1:0] now;
        t_opcode          opcode;
    } t_item;

    localparam int ITEM_W  = $bits(t_item);
    localparam int IN_TD_W = ((ITEM_W + 7) / 8) * 8;

    typedef struct packed {
        t_mode mode;
        t_pat  on_period;
        t_pat  off_period;
        t_pat  blinks_left;
        t_pat  shown;
        t_pat  off_mask;
        logic  colour;
    } t_state;

endpackage

/* hdl/lbs_step.sv */
// Next-state and result logic for one LED sequencer command.
// Depends on lbs_pkg; purely combinational.
module lbs_step #(
    parameter int TIME_WIDTH = lbs_pkg::TIME_WIDTH_DEF
) (
    input  lbs_pkg::t_cfg          i_cfg,
    input  lbs_pkg::t_state        i_state,
    input  logic [TIME_WIDTH-1:0]  i_next_time,
    input  lbs_pkg::t_item         i_item,
    output lbs_pkg::t_state        o_state,
    output logic [TIME_WIDTH-1:0]  o_next_time,
    output logic                   o_emit,
    output lbs_pkg::t_pat          o_pat
);

    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_now_on;
    logic [TIME_WIDTH-1:0] w_now_off;
    lbs_pkg::t_pat         w_code;

    assign w_now     = TIME_WIDTH'(i_item.now);
    assign w_now_on  = w_now + TIME_WIDTH'(i_state.on_period);
    assign w_now_off = w_now + TIME_WIDTH'(i_state.off_period);
    assign w_code    = i_item.display_code;

    always_comb begin
        o_state     = i_state;
        o_next_time = i_next_time;
        o_emit      = 1'b0;
        o_pat       = '0;
        unique case (i_item.opcode)
            lbs_pkg::OP_TICK: begin
                if (!i_cfg.sleep) begin
                    if (((i_state.mode & lbs_pkg::MODE_BLINK) != '0)
                            && (w_now >= i_next_time)) begin
                        if ((i_state.mode & lbs_pkg::MODE_ON) != '0) begin
                            // end of an on phase: drop to off
                            o_next_time  = w_now_off;
                            o_state.mode = i_state.mode & ~lbs_pkg::MODE_ON;
                            o_pat  = i_state.colour ? i_cfg.all_off : i_state.off_mask;
                            o_emit = 1'b1;
                            if ((i_state.mode & lbs_pkg::MODE_FLASH) == '0) begin
                                o_state.blinks_left = i_state.blinks_left - 16'd1;
                                if (i_state.blinks_left == 16'd1) begin
                                    o_state.colour = 1'b0;
                                end
                            end
                        end else if ((i_state.blinks_left == '0)
                                && ((i_state.mode & lbs_pkg::MODE_FLASH) == '0)) begin
                            o_state.mode = i_state.mode & ~lbs_pkg::MODE_BLINK;
                        end else begin
                            o_next_time  = w_now_on;
                            o_state.mode = i_state.mode | lbs_pkg::MODE_ON;
                            o_pat  = i_state.shown;
                            o_emit = 1'b1;
                            if ((i_state.mode & lbs_pkg::MODE_STOP) != '0) begin
                                o_state.mode = lbs_pkg::MODE_ON;
                            end
                        end
                    end
                    // on-once sees the flags and time left by the blink step
                    if (((o_state.mode & lbs_pkg::MODE_ONCE) != '0)
                            && (w_now >= o_next_time)) begin
                        if ((o_state.mode & lbs_pkg::MODE_ON) != '0) begin
                            o_state.mode = o_state.mode
                                & ~(lbs_pkg::MODE_ON | lbs_pkg::MODE_ONCE);
                            o_pat = i_state.off_mask;
                        end else begin
                            o_next_time  = w_now_on;
                            o_state.mode = o_state.mode | lbs_pkg::MODE_ON;
                            o_pat = i_state.shown;
                        end
                        o_emit = 1'b1;
                    end
                end
            end
            lbs_pkg::OP_BLINK: begin
                o_state.colour      = (w_code == i_cfg.red) || (w_code == i_cfg.green);
                o_state.off_period  = i_item.off_time;
                o_state.on_period   = i_item.on_time;
                o_state.blinks_left = i_item.blink_count;
                o_state.shown       = w_code;
                o_state.mode        = (i_item.blink_count == '0)
                    ? (lbs_pkg::MODE_BLINK | lbs_pkg::MODE_FLASH) : lbs_pkg::MODE_BLINK;
                o_next_time         = w_now;
            end
            lbs_pkg::OP_ON: begin
                o_state.mode  = lbs_pkg::MODE_ON;
                o_state.shown = w_code;
                o_pat  = w_code;
                o_emit = 1'b1;
            end
            lbs_pkg::OP_OFF: begin
                o_state.mode  = lbs_pkg::MODE_NONE;
                o_state.shown = w_code;
                o_pat  = w_code;
                o_emit = 1'b1;
            end
            lbs_pkg::OP_PRESET: begin
                o_state.off_period  = lbs_pkg::PRESET_PERIOD;
                o_state.on_period   = lbs_pkg::PRESET_PERIOD;
                o_state.blinks_left = lbs_pkg::PRESET_COUNT;
                o_state.shown       = w_code;
                o_state.mode        = lbs_pkg::MODE_BLINK;
                o_next_time         = w_now;
            end
            lbs_pkg::OP_FLASH: begin
                o_state.mode        = lbs_pkg::MODE_BLINK | lbs_pkg::MODE_FLASH;
                o_state.off_period  = lbs_pkg::PRESET_PERIOD;
                o_state.on_period   = lbs_pkg::PRESET_PERIOD;
                o_state.blinks_left = '0;
                o_state.shown       = w_code;
            end
            lbs_pkg::OP_STOP: begin
                o_state.mode = i_state.mode | lbs_pkg::MODE_STOP;
            end
            lbs_pkg::OP_ON_ONCE: begin
                o_state.on_period = i_item.on_time;
                o_state.shown     = w_code;
                o_state.mode      = lbs_pkg::MODE_ONCE;
                o_next_time       = w_now;
            end
            lbs_pkg::OP_BATT_ON: begin
                o_state.off_mask = i_state.off_mask & ~i_cfg.batt_mask;
                o_pat  = ~i_cfg.batt_mask & i_cfg.all_off;
                o_emit = 1'b1;
            end
            lbs_pkg::OP_BATT_OFF: begin
                o_state.off_mask = i_state.off_mask | i_cfg.batt_mask;
                o_pat  = i_cfg.batt_mask | i_cfg.all_off;
                o_emit = 1'b1;
            end
            lbs_pkg::OP_OPEN_ON: begin
                o_state.off_mask = i_state.off_mask & ~i_cfg.open_mask;
                o_pat  = ~i_cfg.open_mask & i_cfg.blue_on;
                o_emit = 1'b1;
            end
            lbs_pkg::OP_OPEN_OFF: begin
                o_state.off_mask = i_state.off_mask | i_cfg.open_mask;
                o_pat  = i_cfg.open_mask | i_cfg.all_off;
                o_emit = 1'b1;
            end
            default: begin
                // unused opcodes: no change, no result
                o_emit = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/led_blink_sequencer.sv */
// Top level of the LED blink sequencer: request stage, state, result stage.
// Depends on lbs_pkg, lbs_step and led_blink_sequencer_assert.svh.
//
//   Channel   Dir  Handshake                     Carries
//   s_axis    in   s_axis_tvalid/s_axis_tready   one command request
//   m_axis    out  m_axis_tvalid/m_axis_tready   one LED pattern
//   cfg       in   i_cfg_we (no back-pressure)   register index and value
//
// One request per cycle sustained while no result is held. An accepted request is
// registered in the input stage; from there the step logic updates the blink state and,
// if it shifts a pattern out, loads the result register, which drives m_axis_tvalid.
// A held result stalls the input stage once a request waits in it, whether or not
// that request emits, so s_axis_tready then follows m_axis_tready.
// i_rst_n (synchronous, active low) restores the configuration registers, the valid flags and blink state.
`include "led_blink_sequencer_assert.svh"

module led_blink_sequencer #(
    parameter int TIME_WIDTH = lbs_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command requests
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] opcode, [35:4] now, [51:36] display_code, [67:52] blink_count,
    // [83:68] on_time, [99:84] off_time, [103:100] zero
    input  logic [lbs_pkg::IN_TD_W-1:0]   s_axis_tdata,
    // LED patterns
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] led_pattern
    output logic [lbs_pkg::PAT_W-1:0]     m_axis_tdata,
    // register writes
    input  logic                          i_cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbs_pkg::PAT_W-1:0]     i_cfg_data
);

    // Configuration registers
    lbs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.all_off   <= lbs_pkg::ALL_OFF_RST;
            r_cfg.blue_on   <= lbs_pkg::BLUE_ON_RST;
            r_cfg.red       <= lbs_pkg::RED_RST;
            r_cfg.green     <= lbs_pkg::GREEN_RST;
            r_cfg.batt_mask <= '0;
            r_cfg.open_mask <= '0;
            r_cfg.sleep     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (lbs_pkg::t_cfg_idx'(i_cfg_idx))
                lbs_pkg::CFG_ALL_OFF: r_cfg.all_off   <= i_cfg_data;
                lbs_pkg::CFG_BLUE_ON: r_cfg.blue_on   <= i_cfg_data;
                lbs_pkg::CFG_RED:     r_cfg.red       <= i_cfg_data;
                lbs_pkg::CFG_GREEN:   r_cfg.green     <= i_cfg_data;
                lbs_pkg::CFG_BATT:    r_cfg.batt_mask <= i_cfg_data;
                lbs_pkg::CFG_OPEN:    r_cfg.open_mask <= i_cfg_data;
                lbs_pkg::CFG_SLEEP:   r_cfg.sleep     <= i_cfg_data[0];
                default: ;  // writes past the last register are dropped
            endcase
        end
    end

    // Input stage
    logic           r_in_vld;
    lbs_pkg::t_item r_item;
    logic           w_in_acc;
    logic           w_adv;

    // Advance the held request whenever the result slot is free or draining.
    assign w_adv         = r_in_vld && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= lbs_pkg::t_item'(s_axis_tdata[lbs_pkg::ITEM_W-1:0]);
        end
    end

    // Blink state
    lbs_pkg::t_state       r_state;
    lbs_pkg::t_state       n_state;
    logic [TIME_WIDTH-1:0] r_next_time;
    logic [TIME_WIDTH-1:0] n_next_time;
    logic                  w_emit;
    lbs_pkg::t_pat         w_pat;

    lbs_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_next_time (r_next_time),
        .i_item      (r_item),
        .o_state     (n_state),
        .o_next_time (n_next_time),
        .o_emit      (w_emit),
        .o_pat       (w_pat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= lbs_pkg::MODE_NONE;
            r_state.on_period   <= lbs_pkg::PRESET_PERIOD;
            r_state.off_period  <= lbs_pkg::PRESET_PERIOD;
            r_state.blinks_left <= '0;
            r_state.shown       <= lbs_pkg::ALL_OFF_RST;
            r_state.off_mask    <= lbs_pkg::ALL_OFF_RST;
            r_state.colour      <= 1'b0;
            r_next_time         <= TIME_WIDTH'(lbs_pkg::PRESET_PERIOD);
        end else if (w_adv) begin
            r_state     <= n_state;
            r_next_time <= n_next_time;
        end
    end

    // Result stage
    logic          r_out_vld;
    lbs_pkg::t_pat r_out_pat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_pat <= w_pat;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_pat;

    // Checks
    `LBS_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_adv && w_emit, r_out_vld,
        "emitting request did not load the result register")
    `LBS_ASSERT_NEXT(a_request_held, i_clk, i_rst_n, w_in_acc, r_in_vld,
        "accepted request not held in the input stage")
    `LBS_ASSERT_IMPL(a_blink_once_excl, i_clk, i_rst_n, r_in_vld || !r_in_vld,
        ((r_state.mode & lbs_pkg::MODE_BLINK) == '0)
            || ((r_state.mode & lbs_pkg::MODE_ONCE) == '0),
        "blink and on-once active together")

endmodule

/* verif/tb_led_blink_sequencer.sv */
// Self-checking testbench for led_blink_sequencer: drives command requests, predicts
// every LED pattern with a behavioral copy of the blink state, and checks the outputs.
// Depends on lbs_pkg and the led_blink_sequencer RTL only.
module tb_led_blink_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes outside the defined set; the block must drop them silently.
    localparam logic [3:0] OP_UNUSED_FIRST = 4'd12;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    localparam int SETTLE_CYCLES   = 8;    // lets the input and result stages drain
    localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall for the pressure test
    localparam int WATCHDOG_LIMIT  = 4000; // cycles without any handshake
    localparam int RANDOM_QUOTA    = 70;   // requests per register setting

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // [3:0] opcode, [35:4] now, [51:36] display_code, [67:52] blink_count,
    // [83:68] on_time, [99:84] off_time, [103:100] zero
    logic [lbs_pkg::IN_TD_W-1:0]   s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [15:0] led_pattern
    logic [lbs_pkg::PAT_W-1:0]     m_axis_tdata;
    logic                          i_cfg_we      = 1'b0;
    logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [lbs_pkg::PAT_W-1:0]     i_cfg_data    = '0;

    led_blink_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock: 2 ns low, 2 ns high.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the block: register file and blink state.
    // ------------------------------------------------------------------
    lbs_pkg::t_cfg             led_cfg;
    lbs_pkg::t_mode            led_mode;
    logic [lbs_pkg::NOW_W-1:0] led_next_due;
    lbs_pkg::t_pat             led_on_period;
    lbs_pkg::t_pat             led_off_period;
    lbs_pkg::t_pat             led_blinks_left;
    lbs_pkg::t_pat             led_shown;
    lbs_pkg::t_pat             led_off_mask;
    logic                      led_color;

    // Patterns the block still owes, oldest first.
    lbs_pkg::t_pat pending_patterns[$];

    int   err_count        = 0;
    int   requests_counted = 0;  // requests that the block does not ignore
    int   burst_left       = 0;
    int   gap_max          = 6;  // 0 keeps tvalid up with no gaps
    logic [lbs_pkg::NOW_W-1:0] cmd_time = '0;

    // Receiver controls, shared with its own process.
    logic stall_request = 1'b0;
    int   stall_left    = 0;
    int   ready_run     = 0;
    int   ready_pct     = 100;

    int            quiet_cycles  = 0;
    lbs_pkg::t_pat check_want;

    function automatic logic mode_has(input lbs_pkg::t_mode flag);
        return (led_mode & flag) != lbs_pkg::MODE_NONE;
    endfunction

    function automatic lbs_pkg::t_pat rand16();
        return lbs_pkg::t_pat'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic reset_led_model();
        led_cfg.all_off   = lbs_pkg::ALL_OFF_RST;
        led_cfg.blue_on   = lbs_pkg::BLUE_ON_RST;
        led_cfg.red       = lbs_pkg::RED_RST;
        led_cfg.green     = lbs_pkg::GREEN_RST;
        led_cfg.batt_mask = '0;
        led_cfg.open_mask = '0;
        led_cfg.sleep     = 1'b0;
        led_mode          = lbs_pkg::MODE_NONE;
        led_next_due      = lbs_pkg::NOW_W'(lbs_pkg::PRESET_PERIOD);
        led_on_period     = lbs_pkg::PRESET_PERIOD;
        led_off_period    = lbs_pkg::PRESET_PERIOD;
        led_blinks_left   = '0;
        led_shown         = 16'hFFFF;
        led_off_mask      = 16'hFFFF;
        led_color         = 1'b0;
    endtask

    // Apply one accepted request to the blink state and queue the pattern it
    // shifts out, if any.
    task automatic advance_led_state(input logic [3:0] op,
                                     input logic [lbs_pkg::NOW_W-1:0] now,
                                     input lbs_pkg::t_pat code, input lbs_pkg::t_pat count,
                                     input lbs_pkg::t_pat ton, input lbs_pkg::t_pat toff);
        logic          emit;
        lbs_pkg::t_pat pat;
        emit = 1'b0;
        pat  = '0;
        case (op)
            lbs_pkg::OP_TICK: begin
                if (!led_cfg.sleep) begin
                    if (mode_has(lbs_pkg::MODE_BLINK) && now >= led_next_due) begin
                        if (mode_has(lbs_pkg::MODE_ON)) begin
                            // on phase expired: go dark, count the blink
                            led_next_due = now + led_off_period;
                            led_mode     = led_mode & ~lbs_pkg::MODE_ON;
                            pat          = led_color ? led_cfg.all_off : led_off_mask;
                            emit         = 1'b1;
                            if (!mode_has(lbs_pkg::MODE_FLASH)) begin
                                led_blinks_left = led_blinks_left - 1'b1;
                                if (led_blinks_left == '0) begin
                                    led_color = 1'b0;
                                end
                            end
                        end else if (led_blinks_left == '0
                                && !mode_has(lbs_pkg::MODE_FLASH)) begin
                            // last off phase done: drop out of blink, nothing shown
                            led_mode = led_mode & ~lbs_pkg::MODE_BLINK;
                        end else begin
                            led_next_due = now + led_on_period;
                            led_mode     = led_mode | lbs_pkg::MODE_ON;
                            pat          = led_shown;
                            emit         = 1'b1;
                            // a pending stop freezes the pattern on
                            if (mode_has(lbs_pkg::MODE_STOP)) begin
                                led_mode = lbs_pkg::MODE_ON;
                            end
                        end
                    end
                    if (mode_has(lbs_pkg::MODE_ONCE) && now >= led_next_due) begin
                        if (mode_has(lbs_pkg::MODE_ON)) begin
                            led_mode = led_mode & ~(lbs_pkg::MODE_ON | lbs_pkg::MODE_ONCE);
                            pat      = led_off_mask;
                        end else begin
                            led_next_due = now + led_on_period;
                            led_mode     = led_mode | lbs_pkg::MODE_ON;
                            pat          = led_shown;
                        end
                        emit = 1'b1;
                    end
                end
            end
            lbs_pkg::OP_BLINK: begin
                led_color       = (code == led_cfg.red) || (code == led_cfg.green);
                led_off_period  = toff;
                led_on_period   = ton;
                led_blinks_left = count;
                led_shown       = code;
                led_mode        = (count == '0) ? (lbs_pkg::MODE_BLINK | lbs_pkg::MODE_FLASH)
                                                : lbs_pkg::MODE_BLINK;
                led_next_due    = now;
            end
            lbs_pkg::OP_ON: begin
                led_mode  = lbs_pkg::MODE_ON;
                led_shown = code;
                pat       = code;
                emit      = 1'b1;
            end
            lbs_pkg::OP_OFF: begin
                led_mode  = lbs_pkg::MODE_NONE;
                led_shown = code;
                pat       = code;
                emit      = 1'b1;
            end
            lbs_pkg::OP_PRESET: begin
                led_off_period  = lbs_pkg::PRESET_PERIOD;
                led_on_period   = lbs_pkg::PRESET_PERIOD;
                led_blinks_left = lbs_pkg::PRESET_COUNT;
                led_shown       = code;
                led_next_due    = now;
                led_mode        = lbs_pkg::MODE_BLINK;
            end
            lbs_pkg::OP_FLASH: begin
                // next_due is left alone: the first tick may fire at once
                led_mode        = lbs_pkg::MODE_FLASH | lbs_pkg::MODE_BLINK;
                led_off_period  = lbs_pkg::PRESET_PERIOD;
                led_on_period   = lbs_pkg::PRESET_PERIOD;
                led_blinks_left = '0;
                led_shown       = code;
            end
            lbs_pkg::OP_STOP: begin
                led_mode = led_mode | lbs_pkg::MODE_STOP;
            end
            lbs_pkg::OP_ON_ONCE: begin
                led_on_period = ton;
                led_shown     = code;
                led_next_due  = now;
                led_mode      = lbs_pkg::MODE_ONCE;
            end
            lbs_pkg::OP_BATT_ON: begin
                led_off_mask = led_off_mask & ~led_cfg.batt_mask;
                pat          = ~led_cfg.batt_mask & led_cfg.all_off;
                emit         = 1'b1;
            end
            lbs_pkg::OP_BATT_OFF: begin
                led_off_mask = led_off_mask | led_cfg.batt_mask;
                pat          = led_cfg.batt_mask | led_cfg.all_off;
                emit         = 1'b1;
            end
            lbs_pkg::OP_OPEN_ON: begin
                led_off_mask = led_off_mask & ~led_cfg.open_mask;
                pat          = ~led_cfg.open_mask & led_cfg.blue_on;
                emit         = 1'b1;
            end
            lbs_pkg::OP_OPEN_OFF: begin
                led_off_mask = led_off_mask | led_cfg.open_mask;
                pat          = led_cfg.open_mask | led_cfg.all_off;
                emit         = 1'b1;
            end
            default: begin
            end
        endcase
        if (emit) begin
            pending_patterns.push_back(pat);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request at the falling edge, hold it until the handshake, then
    // update the prediction. Between bursts drop tvalid for a random gap.
    task automatic issue_request(input logic [3:0] op, input logic [lbs_pkg::NOW_W-1:0] now,
                                 input lbs_pkg::t_pat code, input lbs_pkg::t_pat count,
                                 input lbs_pkg::t_pat ton, input lbs_pkg::t_pat toff);
        @(negedge i_clk);
        if (gap_max > 0 && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tdata  <= {{(lbs_pkg::IN_TD_W - lbs_pkg::ITEM_W){1'b0}},
                          toff, ton, count, code, now, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_led_state(op, now, code, count, ton, toff);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (op <= lbs_pkg::OP_OPEN_OFF) begin
            requests_counted++;
        end
    endtask

    // Tick with random content in the fields it does not use.
    task automatic send_tick(input logic [lbs_pkg::NOW_W-1:0] now);
        issue_request(lbs_pkg::OP_TICK, now, rand16(), rand16(), rand16(), rand16());
    endtask

    // Drop tvalid, wait for every owed pattern, then let the pipeline drain.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_patterns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; only called while the block is idle.
    task automatic write_reg(input lbs_pkg::t_cfg_idx idx, input lbs_pkg::t_pat value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            lbs_pkg::CFG_ALL_OFF: led_cfg.all_off   = value;
            lbs_pkg::CFG_BLUE_ON: led_cfg.blue_on   = value;
            lbs_pkg::CFG_RED:     led_cfg.red       = value;
            lbs_pkg::CFG_GREEN:   led_cfg.green     = value;
            lbs_pkg::CFG_BATT:    led_cfg.batt_mask = value;
            lbs_pkg::CFG_OPEN:    led_cfg.open_mask = value;
            lbs_pkg::CFG_SLEEP:   led_cfg.sleep     = value[0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_register_set(input lbs_pkg::t_pat all_off, input lbs_pkg::t_pat blue,
                                      input lbs_pkg::t_pat red, input lbs_pkg::t_pat green,
                                      input lbs_pkg::t_pat batt, input lbs_pkg::t_pat open,
                                      input logic sleep);
        write_reg(lbs_pkg::CFG_ALL_OFF, all_off);
        write_reg(lbs_pkg::CFG_BLUE_ON, blue);
        write_reg(lbs_pkg::CFG_RED, red);
        write_reg(lbs_pkg::CFG_GREEN, green);
        write_reg(lbs_pkg::CFG_BATT, batt);
        write_reg(lbs_pkg::CFG_OPEN, open);
        // only bit 0 counts; fill the rest with noise
        write_reg(lbs_pkg::CFG_SLEEP, {15'(rand16()), sleep});
    endtask

    // Mostly well-formed blink sequences (start command, then ticks with time
    // moving forward), the rest static commands and plain noise.
    task automatic run_blink_traffic(input int quota);
        int            start_count;
        int            kind;
        int            pick;
        int            step;
        logic [3:0]    op;
        lbs_pkg::t_pat code;
        lbs_pkg::t_pat count;
        lbs_pkg::t_pat ton;
        lbs_pkg::t_pat toff;
        start_count = requests_counted;
        while (requests_counted - start_count < quota) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    op = lbs_pkg::OP_BLINK;
                end else if (pick == 5) begin
                    op = lbs_pkg::OP_PRESET;
                end else if (pick == 6) begin
                    op = lbs_pkg::OP_FLASH;
                end else begin
                    op = lbs_pkg::OP_ON_ONCE;
                end
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    code = led_cfg.red;
                end else if (pick < 45) begin
                    code = led_cfg.green;
                end else begin
                    code = rand16();
                end
                count = ($urandom_range(0, 9) == 0) ? rand16()
                                                    : lbs_pkg::t_pat'($urandom_range(0, 4));
                ton   = ($urandom_range(0, 6) == 0) ? rand16()
                                                    : lbs_pkg::t_pat'($urandom_range(0, 40));
                toff  = ($urandom_range(0, 6) == 0) ? rand16()
                                                    : lbs_pkg::t_pat'($urandom_range(0, 40));
                // now and then start just below the top of the time range
                if ($urandom_range(0, 19) == 0) begin
                    cmd_time = 32'hFFFF_FFFF - $urandom_range(0, 400);
                end
                issue_request(op, cmd_time, code, count, ton, toff);
                repeat ($urandom_range(4, 30)) begin
                    step = $urandom_range(0, 99);
                    if (step < 5) begin
                        issue_request(lbs_pkg::OP_STOP, cmd_time, rand16(), rand16(),
                                      rand16(), rand16());
                    end else if (step < 10) begin
                        op = 4'(lbs_pkg::OP_BATT_ON + $urandom_range(0, 3));
                        issue_request(op, cmd_time, rand16(), rand16(), rand16(), rand16());
                    end
                    if ($urandom_range(0, 19) == 0) begin
                        cmd_time = cmd_time + $urandom_range(0, 70000);
                    end else begin
                        cmd_time = cmd_time + $urandom_range(0, 30);
                    end
                    send_tick(cmd_time);
                end
            end else if (kind < 80) begin
                op = 4'($urandom_range(lbs_pkg::OP_ON, lbs_pkg::OP_OFF));
                if ($urandom_range(0, 1) == 0) begin
                    op = 4'(lbs_pkg::OP_BATT_ON + $urandom_range(0, 3));
                end
                issue_request(op, cmd_time, rand16(), rand16(), rand16(), rand16());
            end else begin
                op = 4'($urandom_range(0, OP_UNUSED_LAST));
                issue_request(op, $urandom(), rand16(), rand16(), rand16(), rand16());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every opcode, field extremes, color handling, stop, on-once end,
    // endless flash, time wrap and two unused opcodes.
    task automatic test_directed();
        write_reg(lbs_pkg::CFG_BATT, 16'h000F);
        write_reg(lbs_pkg::CFG_OPEN, 16'h00F0);
        write_reg(lbs_pkg::CFG_BLUE_ON, 16'h1200);
        send_tick('0);                                     // idle: nothing shown
        issue_request(lbs_pkg::OP_OFF, '0, 16'h0000, '0, '0, '0);
        issue_request(lbs_pkg::OP_ON, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue_request(lbs_pkg::OP_BATT_ON, 32'd10, '0, '0, '0, '0);
        issue_request(lbs_pkg::OP_OPEN_ON, 32'd10, '0, '0, '0, '0);
        // single blink with zero-length phases, plain color: off phase uses off mask
        issue_request(lbs_pkg::OP_BLINK, 32'd1000, 16'h1234, 16'd1, 16'd0, 16'd0);
        send_tick(32'd1000);
        send_tick(32'd1000);
        send_tick(32'd1000);
        // endless red flash: off phase drives the all-off pattern, then stop
        issue_request(lbs_pkg::OP_BLINK, 32'd2000, lbs_pkg::RED_RST, 16'd0, 16'd5, 16'd5);
        send_tick(32'd2000);
        send_tick(32'd2005);
        issue_request(lbs_pkg::OP_STOP, 32'd2006, '0, '0, '0, '0);
        send_tick(32'd2010);
        send_tick(32'd3000);
        // preset blink across the top of the time range
        issue_request(lbs_pkg::OP_PRESET, 32'hFFFF_FFF0, lbs_pkg::GREEN_RST, '0, '0, '0);
        send_tick(32'hFFFF_FFF0);
        send_tick(32'hFFFF_FFF1);
        send_tick(32'hFFFF_FFFF);
        // single long on phase, then its end
        issue_request(lbs_pkg::OP_ON_ONCE, 32'd5, 16'h0F0F, '0, 16'hFFFF, '0);
        send_tick(32'd5);
        send_tick(32'd70000);
        issue_request(lbs_pkg::OP_BATT_OFF, 32'd70001, '0, '0, '0, '0);
        issue_request(lbs_pkg::OP_OPEN_OFF, 32'd70002, '0, '0, '0, '0);
        issue_request(lbs_pkg::OP_FLASH, 32'd70003, 16'hA5A5, '0, '0, '0);
        issue_request(OP_UNUSED_LAST, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue_request(OP_UNUSED_FIRST, 32'd0, '0, '0, '0, '0);
        send_tick(32'd70010);
    endtask

    // Random traffic under a series of register settings, extremes included.
    task automatic test_register_sweep();
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                0: apply_register_set('0, '0, '0, '0, '0, '0, 1'b0);
                1: apply_register_set('1, '1, '1, '1, '1, '1, 1'b0);
                2: apply_register_set(rand16(), rand16(), rand16(), rand16(),
                                      rand16(), rand16(), 1'b1);   // ticks frozen
                7: apply_register_set(lbs_pkg::ALL_OFF_RST, lbs_pkg::BLUE_ON_RST,
                                      lbs_pkg::RED_RST, lbs_pkg::GREEN_RST,
                                      '0, '0, 1'b0);
                default: apply_register_set(rand16(), rand16(), rand16(), rand16(),
                                            rand16(), rand16(), 1'b0);
            endcase
            gap_max = (phase % 3 == 1) ? 0 : $urandom_range(2, 8);
            run_blink_traffic(RANDOM_QUOTA);
        end
        gap_max = 6;
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so the block fills and backs up its input.
    task automatic test_output_backpressure();
        settle();
        gap_max = 0;
        stall_request = 1'b1;
        repeat (40) begin
            issue_request(4'($urandom_range(lbs_pkg::OP_ON, lbs_pkg::OP_OFF)), cmd_time,
                          rand16(), rand16(), rand16(), rand16());
        end
        gap_max = 6;
    endtask

    // Short bursts, each followed by a pause until every pattern is back.
    task automatic test_drain_pause();
        repeat (6) begin
            run_blink_traffic(8);
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver: long hold-off on request, otherwise a ready duty cycle that
    // is redrawn after each random run (full rate stretches included).
    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_left    = HOLD_OFF_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (ready_run == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 90;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
                ready_run = $urandom_range(8, 64);
            end
            ready_run--;
            m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare each accepted pattern with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_patterns.size() == 0) begin
                report_mismatch($sformatf("pattern %h with none owed", m_axis_tdata));
            end else begin
                check_want = pending_patterns.pop_front();
                if (m_axis_tdata !== check_want) begin
                    report_mismatch($sformatf("led_pattern %h, predicted %h",
                                              m_axis_tdata, check_want));
                end
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d patterns owed",
                     quiet_cycles, pending_patterns.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        reset_led_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_register_sweep();
        test_output_backpressure();
        test_drain_pause();
        settle();

        if (err_count == 0 && pending_patterns.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
